// ----- rtl/dbt_pkg.sv -----
// shared types and constants for the debug breakpoint trigger
package dbt_pkg;

   // action codes
   localparam logic [1:0] ACT_EVENT  = 2'd0;
   localparam logic [1:0] ACT_CMD    = 2'd1;
   localparam logic [1:0] ACT_ENABLE = 2'd2;

   // command types, also the stepping modes
   localparam logic [3:0] BT_RUN        = 4'd0;
   localparam logic [3:0] BT_STEP       = 4'd1;
   localparam logic [3:0] BT_STEP_LINE  = 4'd2;
   localparam logic [3:0] BT_TO_LINE    = 4'd3;
   localparam logic [3:0] BT_PARENT     = 4'd4;
   localparam logic [3:0] BT_PARENT_PRG = 4'd5;
   localparam logic [3:0] BT_TRACE      = 4'd6;
   localparam logic [3:0] BT_ADD        = 4'd7;
   localparam logic [3:0] BT_CLEAR      = 4'd8;
   localparam logic [3:0] BT_CLEAR_LINE = 4'd9;
   localparam logic [3:0] BT_GOTO       = 4'd10;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_FULL    = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL = 2'd2;

   // request payload, last member in the lowest bits
   typedef struct packed {
      logic        enable;
      logic        watch_hit;
      logic [15:0] parent_gosub_level;
      logic [15:0] gosub_level;
      logic [14:0] call_level;
      logic [31:0] program_id;
      logic [7:0]  sub_ref;
      logic [15:0] line_number;
      logic [16:0] qualifier;
   } req_fields_type;

   typedef struct packed {
      logic [1:0]  error_code;
      logic [7:0]  break_sub_ref;
      logic [15:0] break_line;
      logic [31:0] debugged_program;
      logic [1:0]  event_bits;
      logic        break_flag;
   } rsp_fields_type;

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 6;
   localparam int RSP_DATA_W = 64;
   localparam int REQ_BITS   = $bits(req_fields_type);
   localparam int RSP_BITS   = $bits(rsp_fields_type);

   // breakpoint table
   typedef struct packed {
      logic [15:0] line;
      logic [31:0] id;
   } bp_entry_type;

   typedef enum logic [1:0] {
      TBL_SEARCH,
      TBL_ADD,
      TBL_CLEAR,
      TBL_REMOVE
   } tbl_op_type;

   typedef struct packed {
      logic        start;
      tbl_op_type  op;
      logic [15:0] line;
      logic [31:0] id;
   } tbl_cmd_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } tbl_stat_type;

endpackage

// ----- rtl/dbt_table.sv -----
// breakpoint table: entry memory with a scan, append and compacting remove sequencer
module dbt_table
   import dbt_pkg::*;
#(
   parameter int BP_ENTRIES = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  tbl_cmd_type  tbl_cmd,
   output tbl_stat_type tbl_stat
);

   localparam int IW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
   localparam int CW = $clog2(BP_ENTRIES + 1);
   localparam logic [CW-1:0] USED_MAX = CW'(BP_ENTRIES);

   typedef enum logic [1:0] {
      T_IDLE,
      T_SCAN,
      T_SHIFT
   } tstate_type;

   tstate_type   state_ff, state_in;
   tbl_op_type   op_ff, op_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   logic         pend_ff, pend_in;
   logic         done_ff, done_in;
   logic         hit_ff, hit_in;
   logic         full_ff, full_in;

   bp_entry_type mem [BP_ENTRIES];
   bp_entry_type rd_data_ff;
   logic         wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   bp_entry_type wr_data;
   logic         match;

   // shared compare unit
   assign match = pend_ff && (rd_data_ff.line == tbl_cmd.line) && (rd_data_ff.id == tbl_cmd.id);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      used_in     = used_ff;
      ptr_in      = ptr_ff;
      pend_idx_in = pend_idx_ff;
      pend_in     = 1'b0;
      done_in     = 1'b0;
      hit_in      = hit_ff;
      full_in     = full_ff;
      wr_en       = 1'b0;
      wr_addr     = used_ff[IW-1:0];
      wr_data     = '{line: tbl_cmd.line, id: tbl_cmd.id};
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[IW-1:0];
      unique case (state_ff)
         T_IDLE: begin
            if (tbl_cmd.start) begin
               op_in = tbl_cmd.op;
               unique case (tbl_cmd.op)
                  TBL_SEARCH, TBL_REMOVE: begin
                     ptr_in   = '0;
                     hit_in   = 1'b0;
                     state_in = T_SCAN;
                  end
                  TBL_ADD: begin
                     done_in = 1'b1;
                     if (used_ff == USED_MAX) begin
                        full_in = 1'b1;
                     end else begin
                        full_in = 1'b0;
                        wr_en   = 1'b1;
                        used_in = used_ff + CW'(1);
                     end
                  end
                  TBL_CLEAR: begin
                     done_in = 1'b1;
                     used_in = '0;
                  end
               endcase
            end
         end
         T_SCAN: begin
            priority if (match) begin
               hit_in = 1'b1;
               if (op_ff == TBL_REMOVE) begin
                  ptr_in   = pend_idx_ff + CW'(1);
                  state_in = T_SHIFT;
               end else begin
                  done_in  = 1'b1;
                  state_in = T_IDLE;
               end
            end else if (ptr_ff < used_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff;
               ptr_in      = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               done_in  = 1'b1;
               state_in = T_IDLE;
            end else begin
               pend_in = 1'b0;
            end
         end
         T_SHIFT: begin
            // move each later entry down by one place
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(pend_idx_ff - CW'(1));
               wr_data = rd_data_ff;
            end
            if (ptr_ff < used_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff;
               ptr_in      = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               used_in  = used_ff - CW'(1);
               done_in  = 1'b1;
               state_in = T_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      if (reset) begin
         state_ff <= T_IDLE;
         used_ff  <= '0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
         hit_ff   <= hit_in;
         full_ff  <= full_in;
      end
   end

   assign tbl_stat = '{done: done_ff, hit: hit_ff, full: full_ff};

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_MAX)
      else $error("breakpoint count beyond table size");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_cmd.start |-> state_ff == T_IDLE)
      else $error("table command while sequencer busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("table done held for more than one cycle");

endmodule

// ----- rtl/debug_breakpoint_trigger_top.sv -----
// top level of the debug breakpoint trigger: handshake, stepping state and result register
//
// channel  dir  group                 tdata / tuser
// request  in   req_tvalid/tready     event or command fields / action, command type
// response out  rsp_tvalid/tready     break flag, reasons, program, line, error / -
//
// one request at a time: accept, dispatch, table pass, finish
// a line event with debugging on scans the table, one entry read and compared per cycle
//   through a single read port
// clear line scans the table, then compacts it one entry per cycle
// the finished response waits in an output register and the next request is taken
//   while it is held by rsp_tready low
// synchronous active-high reset clears the mode state and the breakpoint count; table
//   memory is not cleared, entries past the count are never read
module debug_breakpoint_trigger_top
   import dbt_pkg::*;
#(
   parameter int BP_ENTRIES = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // qualifier, line_number, sub_ref, program_id, call level, gosub level,
   // parent gosub level, watch_hit, enable, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action, brk_type
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // break flag, event_bits, debugged_program, break_line, break_sub_ref, error_code, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_TABLE,
      S_FINISH
   } state_type;

   state_type      state_ff, state_in;
   req_fields_type req_ff, req_in;
   logic [1:0]     act_ff, act_in;
   logic [3:0]     type_ff, type_in;
   rsp_fields_type rsp_ff, rsp_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;

   // stepping state
   logic           debug_on_ff, debug_on_in;
   logic [3:0]     step_mode_ff, step_mode_in;
   logic [15:0]    step_count_ff, step_count_in;
   logic [31:0]    target_ff, target_in;
   logic [31:0]    saved_word_ff, saved_word_in;
   logic [31:0]    cur_prog_ff, cur_prog_in;

   tbl_cmd_type    tbl_cmd;
   tbl_stat_type   tbl_stat;

   dbt_table #(
      .BP_ENTRIES(BP_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_cmd (tbl_cmd),
      .tbl_stat(tbl_stat)
   );

   always_comb begin
      logic        brk;
      logic [1:0]  ev;
      logic [1:0]  err;
      logic [15:0] cnt_dec;
      logic [15:0] parent_depth;

      state_in      = state_ff;
      req_in        = req_ff;
      act_in        = act_ff;
      type_in       = type_ff;
      rsp_in        = rsp_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      debug_on_in   = debug_on_ff;
      step_mode_in  = step_mode_ff;
      step_count_in = step_count_ff;
      target_in     = target_ff;
      saved_word_in = saved_word_ff;
      cur_prog_in   = cur_prog_ff;
      brk           = 1'b0;
      ev            = 2'b00;
      err           = ERR_NONE;
      cnt_dec       = step_count_ff - 16'd1;
      parent_depth  = {1'b0, req_ff.call_level} - 16'd1;

      // table key: the command argument for commands, the event line otherwise
      tbl_cmd.start = 1'b0;
      tbl_cmd.line  = (act_ff == ACT_CMD) ? req_ff.qualifier[15:0] : req_ff.line_number;
      tbl_cmd.id    = cur_prog_ff;
      priority if (act_ff != ACT_CMD) begin
         tbl_cmd.op = TBL_SEARCH;
      end else if (type_ff == BT_ADD) begin
         tbl_cmd.op = TBL_ADD;
      end else if (type_ff == BT_CLEAR) begin
         tbl_cmd.op = TBL_CLEAR;
      end else begin
         tbl_cmd.op = TBL_REMOVE;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_in   = req_fields_type'(req_tdata[REQ_BITS-1:0]);
               act_in   = req_tuser[1:0];
               type_in  = req_tuser[5:2];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (act_ff == ACT_EVENT && debug_on_ff) begin
               tbl_cmd.start = 1'b1;
               state_in      = S_TABLE;
            end else if (act_ff == ACT_CMD &&
                         (type_ff == BT_ADD || type_ff == BT_CLEAR ||
                          (type_ff == BT_CLEAR_LINE && !req_ff.qualifier[16]))) begin
               // a negative line never matches, so clear line skips the table then
               tbl_cmd.start = 1'b1;
               state_in      = S_TABLE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_TABLE: begin
            if (tbl_stat.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               unique case (act_ff)
                  ACT_EVENT: begin
                     if (debug_on_ff) begin
                        // watch hit and table hit win over the stepping mode
                        ev = {req_ff.watch_hit, tbl_stat.hit};
                        if (ev != 2'b00) begin
                           brk = 1'b1;
                        end else begin
                           unique case (step_mode_ff)
                              BT_RUN: begin
                                 brk = 1'b0;
                              end
                              BT_STEP: begin
                                 step_count_in = cnt_dec;
                                 brk           = (cnt_dec == 16'd0);
                              end
                              BT_STEP_LINE: begin
                                 if (req_ff.sub_ref == 8'd0) begin
                                    step_count_in = cnt_dec;
                                    brk           = (cnt_dec == 16'd0);
                                 end
                              end
                              BT_TO_LINE: begin
                                 brk = (cur_prog_ff == target_ff) &&
                                       (req_ff.line_number == step_count_ff);
                              end
                              BT_PARENT, BT_PARENT_PRG: begin
                                 brk = $signed(saved_word_ff) >
                                       $signed({1'b0, req_ff.call_level, req_ff.gosub_level});
                              end
                              default: begin
                                 brk = 1'b1;
                              end
                           endcase
                        end
                        if (brk) begin
                           cur_prog_in = req_ff.program_id;
                        end
                     end
                  end
                  ACT_CMD: begin
                     step_mode_in = type_ff;
                     unique case (type_ff)
                        BT_RUN, BT_TRACE, BT_GOTO, BT_CLEAR, BT_CLEAR_LINE: begin
                           err = ERR_NONE;
                        end
                        BT_STEP, BT_STEP_LINE: begin
                           step_count_in = req_ff.qualifier[15:0];
                        end
                        BT_TO_LINE: begin
                           target_in     = cur_prog_ff;
                           step_count_in = req_ff.qualifier[15:0];
                        end
                        BT_PARENT: begin
                           saved_word_in = {parent_depth, req_ff.parent_gosub_level};
                        end
                        BT_PARENT_PRG: begin
                           target_in     = cur_prog_ff;
                           saved_word_in = {parent_depth, 16'h0000};
                        end
                        BT_ADD: begin
                           err = tbl_stat.full ? ERR_FULL : ERR_NONE;
                        end
                        default: begin
                           step_mode_in = BT_RUN;
                           err          = ERR_ILLEGAL;
                        end
                     endcase
                  end
                  ACT_ENABLE: begin
                     debug_on_in   = req_ff.enable;
                     step_mode_in  = BT_STEP;
                     step_count_in = 16'd1;
                  end
                  default: begin
                     err = ERR_NONE;
                  end
               endcase
               rsp_in.break_flag       = brk;
               rsp_in.event_bits       = ev;
               rsp_in.debugged_program = cur_prog_in;
               rsp_in.break_line       = brk ? req_ff.line_number : 16'd0;
               rsp_in.break_sub_ref    = brk ? req_ff.sub_ref : 8'd0;
               rsp_in.error_code       = err;
               rsp_tvalid_in           = 1'b1;
               state_in                = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      act_ff  <= act_in;
      type_ff <= type_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         debug_on_ff   <= 1'b0;
         step_mode_ff  <= BT_RUN;
         step_count_ff <= '0;
         target_ff     <= '0;
         saved_word_ff <= '0;
         cur_prog_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         debug_on_ff   <= debug_on_in;
         step_mode_ff  <= step_mode_in;
         step_count_ff <= step_count_in;
         target_ff     <= target_in;
         saved_word_ff <= saved_word_in;
         cur_prog_ff   <= cur_prog_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, rsp_ff};

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_DISPATCH)
      else $error("accepted request not dispatched");

   a_done_in_table: assert property (@(posedge clock) disable iff (reset)
      tbl_stat.done |-> state_ff == S_TABLE)
      else $error("table done outside table wait");

   a_quiet_no_break: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_ff.break_flag) |->
         (rsp_ff.event_bits == 2'b00 && rsp_ff.break_line == 16'd0))
      else $error("break details without a break");

   a_err_no_break: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_ff.error_code != ERR_NONE) |-> !rsp_ff.break_flag)
      else $error("error reported together with a break");

endmodule

// ----- bench/tb_debug_breakpoint_trigger_top.sv -----
// self-checking bench for the debug breakpoint trigger: directed and random requests vs a predictor
`timescale 1ns / 1ps

module tb_debug_breakpoint_trigger_top;
   import dbt_pkg::*;

   localparam int          BP_ENTRIES     = 20;
   localparam int          RANDOM_ITEMS   = 850;
   localparam int          PAUSE_AT       = 450;     // request that waits for a full drain
   localparam int          HOLD_AT        = 300;     // response count that starts the long hold
   localparam int          HOLD_CYCLES    = 400;
   localparam int          TAIL_CYCLES    = 40;      // longer than a full-table scan
   localparam int          CYCLE_LIMIT    = 500000;
   localparam logic [1:0]  ACT_UNUSED     = 2'd3;
   localparam logic [3:0]  BT_ILLEGAL_MAX = 4'd15;
   localparam logic [31:0] PID_A          = 32'h0000_1234;

   // one pending request: sideband codes, payload, and a drain-first marker
   typedef struct {
      logic [1:0]     action;
      logic [3:0]     brk_type;
      req_fields_type f;
      bit             pause;
   } req_item_type;

   typedef enum {SES_TABLE, SES_STEP, SES_TO_LINE, SES_PARENT, SES_FILL, SES_NOISE} session_type;
   typedef enum {RCV_OPEN, RCV_MOSTLY, RCV_SPARSE, RCV_RUNS} rcv_mode_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // dut ports, all driven from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   debug_breakpoint_trigger_top #(
      .BP_ENTRIES (BP_ENTRIES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // request and response bookkeeping
   req_item_type   req_pending_q[$];
   rsp_fields_type rsp_expect_q[$];
   int             req_counted  = 0;
   bit             pause_placed = 1'b0;
   bit             offer_live   = 1'b0;
   int             req_accepted = 0;
   int             rsp_checked  = 0;
   int             err_count    = 0;
   int             cycle_count  = 0;

   // coverage tallies for the closing summary
   int n_breaks = 0, n_tbl_hits = 0, n_watch = 0, n_full = 0, n_illegal = 0;

   // predictor state, mirrors the block after reset
   logic        dbg_on     = 1'b0;
   logic [3:0]  step_mode  = BT_RUN;
   logic [15:0] step_count = '0;
   logic [31:0] tgt_prog   = '0;
   logic [31:0] call_word  = '0;
   logic [31:0] cur_prog   = '0;
   logic [15:0] tbl_line [BP_ENTRIES];
   logic [31:0] tbl_id   [BP_ENTRIES];
   int          tbl_used   = 0;

   // value pools so table, target line and program matches actually happen
   logic [15:0] line_pool [8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd100, 16'd200,
                                  16'd65534, 16'd65535};
   logic [31:0] pid_pool  [4] = '{32'h0000_0000, 32'h0000_0001, PID_A, 32'hFFFF_FFFF};

   // expected response for one request, updating the predictor state
   function automatic rsp_fields_type trigger_predict(input req_item_type it);
      rsp_fields_type r;
      logic           brk;
      logic [1:0]     ev;
      logic [1:0]     err;
      logic [31:0]    depth_m1;
      int             hit_at;
      brk      = 1'b0;
      ev       = 2'b00;
      err      = ERR_NONE;
      hit_at   = -1;
      // parent word wraps when call depth is zero
      depth_m1 = {17'd0, it.f.call_level} - 32'd1;
      case (it.action)
         ACT_EVENT: begin
            // debugging off: nothing changes, no break
            if (dbg_on) begin
               if (it.f.watch_hit) ev[1] = 1'b1;
               for (int i = 0; i < tbl_used; i++) begin
                  if (hit_at < 0 && tbl_line[i] == it.f.line_number && tbl_id[i] == cur_prog)
                     hit_at = i;
               end
               if (hit_at >= 0) ev[0] = 1'b1;
               if (ev != 2'b00) begin
                  brk = 1'b1;
               end else begin
                  case (step_mode)
                     BT_RUN: ;
                     BT_STEP: begin
                        step_count = step_count - 16'd1;
                        brk = (step_count == 16'd0);
                     end
                     BT_STEP_LINE: begin
                        if (it.f.sub_ref == 8'd0) begin
                           step_count = step_count - 16'd1;
                           brk = (step_count == 16'd0);
                        end
                     end
                     BT_TO_LINE: brk = (cur_prog == tgt_prog) && (it.f.line_number == step_count);
                     BT_PARENT, BT_PARENT_PRG:
                        brk = $signed(call_word) >
                              $signed({1'b0, it.f.call_level, it.f.gosub_level});
                     default: brk = 1'b1;
                  endcase
               end
               if (brk) cur_prog = it.f.program_id;
            end
         end
         ACT_CMD: begin
            step_mode = it.brk_type;
            case (it.brk_type)
               BT_RUN, BT_TRACE, BT_GOTO: ;
               BT_STEP, BT_STEP_LINE: step_count = it.f.qualifier[15:0];
               BT_TO_LINE: begin
                  tgt_prog   = cur_prog;
                  step_count = it.f.qualifier[15:0];
               end
               BT_PARENT: call_word = {depth_m1[15:0], it.f.parent_gosub_level};
               BT_PARENT_PRG: begin
                  tgt_prog  = cur_prog;
                  call_word = {depth_m1[15:0], 16'h0000};
               end
               BT_ADD: begin
                  // full table: entries untouched, mode still becomes add
                  if (tbl_used >= BP_ENTRIES) begin
                     err = ERR_FULL;
                  end else begin
                     tbl_line[tbl_used] = it.f.qualifier[15:0];
                     tbl_id[tbl_used]   = cur_prog;
                     tbl_used++;
                  end
               end
               BT_CLEAR: tbl_used = 0;
               BT_CLEAR_LINE: begin
                  // negative qualifier never matches a line
                  if (!it.f.qualifier[16]) begin
                     for (int i = 0; i < tbl_used; i++) begin
                        if (hit_at < 0 && tbl_id[i] == cur_prog &&
                            tbl_line[i] == it.f.qualifier[15:0])
                           hit_at = i;
                     end
                  end
                  if (hit_at >= 0) begin
                     for (int j = hit_at + 1; j < tbl_used; j++) begin
                        tbl_line[j-1] = tbl_line[j];
                        tbl_id[j-1]   = tbl_id[j];
                     end
                     tbl_used--;
                  end
               end
               default: begin
                  step_mode = BT_RUN;
                  err       = ERR_ILLEGAL;
               end
            endcase
         end
         ACT_ENABLE: begin
            dbg_on     = it.f.enable;
            step_mode  = BT_STEP;
            step_count = 16'd1;
         end
         default: ;   // unused action code is ignored
      endcase
      r.break_flag       = brk;
      r.event_bits       = brk ? ev : 2'b00;
      r.debugged_program = cur_prog;
      r.break_line       = brk ? it.f.line_number : 16'd0;
      r.break_sub_ref    = brk ? it.f.sub_ref : 8'd0;
      r.error_code       = err;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // every field random, then the caller overrides what matters
   function automatic req_item_type base_item(input logic [1:0] act, input logic [3:0] bt);
      req_item_type it;
      it.action               = act;
      it.brk_type             = bt;
      it.f.qualifier          = 17'($urandom);
      it.f.line_number        = 16'($urandom);
      it.f.sub_ref            = 8'($urandom);
      it.f.program_id         = $urandom;
      it.f.call_level         = 15'($urandom);
      it.f.gosub_level        = 16'($urandom);
      it.f.parent_gosub_level = 16'($urandom);
      it.f.watch_hit          = 1'($urandom);
      it.f.enable             = 1'($urandom);
      it.pause                = 1'b0;
      return it;
   endfunction

   function automatic logic [15:0] pick_line();
      return ($urandom_range(0, 9) < 7) ? line_pool[$urandom_range(0, 7)] : 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_pid();
      return ($urandom_range(0, 9) < 8) ? pid_pool[$urandom_range(0, 3)] : $urandom;
   endfunction

   task automatic push_req(input req_item_type it);
      // ignored requests do not count toward the item total
      if (it.action != ACT_UNUSED) req_counted++;
      if (!pause_placed && req_counted >= PAUSE_AT) begin
         it.pause     = 1'b1;
         pause_placed = 1'b1;
      end
      req_pending_q.push_back(it);
   endtask

   task automatic cmd(input logic [3:0] bt, input logic [16:0] q);
      req_item_type it;
      it             = base_item(ACT_CMD, bt);
      it.f.qualifier = q;
      push_req(it);
   endtask

   task automatic parent_cmd(input logic [3:0] bt, input logic [14:0] depth,
                             input logic [15:0] pgosub);
      req_item_type it;
      it                      = base_item(ACT_CMD, bt);
      it.f.call_level         = depth;
      it.f.parent_gosub_level = pgosub;
      push_req(it);
   endtask

   task automatic line_ev(input logic [15:0] line, input logic [7:0] sub,
                          input logic [31:0] pid, input logic watch);
      req_item_type it;
      it               = base_item(ACT_EVENT, 4'($urandom));
      it.f.line_number = line;
      it.f.sub_ref     = sub;
      it.f.program_id  = pid;
      it.f.watch_hit   = watch;
      push_req(it);
   endtask

   task automatic depth_ev(input logic [14:0] depth, input logic [15:0] gosub,
                           input logic [31:0] pid);
      req_item_type it;
      it               = base_item(ACT_EVENT, 4'($urandom));
      it.f.call_level  = depth;
      it.f.gosub_level = gosub;
      it.f.program_id  = pid;
      it.f.watch_hit   = 1'b0;
      push_req(it);
   endtask

   task automatic enable_req(input logic en);
      req_item_type it;
      it          = base_item(ACT_ENABLE, 4'($urandom));
      it.f.enable = en;
      push_req(it);
   endtask

   // one well-formed sequence with random content, or a run of noise
   task automatic gen_session(input session_type kind);
      req_item_type it;
      logic [3:0]   bt;
      case (kind)
         SES_TABLE: begin
            if ($urandom_range(0, 9) < 3) cmd(BT_CLEAR, 17'($urandom));
            repeat ($urandom_range(1, 5)) cmd(BT_ADD, {1'($urandom), pick_line()});
            case ($urandom_range(0, 5))
               0:       bt = BT_TRACE;
               1:       bt = BT_GOTO;
               default: bt = BT_RUN;
            endcase
            cmd(bt, 17'($urandom));
            repeat ($urandom_range(4, 12))
               line_ev(pick_line(), 8'($urandom), pick_pid(), $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 4)
               cmd(BT_CLEAR_LINE, {$urandom_range(0, 4) == 0, pick_line()});
         end
         SES_STEP: begin
            bt = $urandom_range(0, 1) ? BT_STEP : BT_STEP_LINE;
            cmd(bt, {1'($urandom), 16'($urandom_range(0, 4))});
            repeat ($urandom_range(3, 8))
               line_ev(pick_line(), $urandom_range(0, 1) ? 8'd0 : 8'($urandom), pick_pid(),
                       $urandom_range(0, 19) == 0);
         end
         SES_TO_LINE: begin
            cmd(BT_TO_LINE, {1'($urandom), pick_line()});
            repeat ($urandom_range(3, 8))
               line_ev(pick_line(), 8'($urandom), pick_pid(), $urandom_range(0, 19) == 0);
         end
         SES_PARENT: begin
            bt = $urandom_range(0, 1) ? BT_PARENT : BT_PARENT_PRG;
            parent_cmd(bt,
                       ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 4)),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)));
            repeat ($urandom_range(3, 8))
               depth_ev(15'($urandom_range(0, 5)),
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
                        pick_pid());
         end
         SES_FILL: begin
            // drives the table toward full, and past it in most sessions
            if ($urandom_range(0, 1)) cmd(BT_CLEAR, 17'($urandom));
            repeat ($urandom_range(18, 24)) cmd(BT_ADD, {1'($urandom), pick_line()});
            cmd(BT_RUN, 17'($urandom));
            repeat ($urandom_range(2, 5))
               line_ev(pick_line(), 8'($urandom), pick_pid(), 1'b0);
         end
         default: begin
            repeat ($urandom_range(2, 6)) begin
               it = base_item(2'($urandom), 4'($urandom));
               push_req(it);
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------- request driver

   int burst_left = 0;
   int gap_left   = 0;

   // changes at the falling edge; a live offer stays put until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!offer_live) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_pending_q.size() == 0 ||
                      (req_pending_q[0].pause && rsp_expect_q.size() != 0)) begin
            // nothing left, or a marked request waits until the block has drained
            req_tvalid <= 1'b0;
         end else begin
            req_pending_q[0].pause = 1'b0;
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, req_pending_q[0].f};
            req_tuser  <= {req_pending_q[0].brk_type, req_pending_q[0].action};
            offer_live = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 9) == 0) begin
               // long stretch with no gaps
               burst_left = $urandom_range(40, 120);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left   = $urandom_range(0, 12);
            end
         end
      end
   end

   // ---------------------------------------------------------------- response receiver

   rcv_mode_type rcv_mode   = RCV_OPEN;
   int           rcv_phase  = 0;
   int           stall_left = 0;
   int           hold_left  = 0;
   bit           hold_done  = 1'b0;

   // its own stall pattern, plus one long hold-off so the block backs up into the input
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_done && rsp_checked >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (rcv_phase == 0) begin
            rcv_mode  = rcv_mode_type'($urandom_range(0, 3));
            rcv_phase = $urandom_range(20, 80);
         end
         rcv_phase--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rcv_mode)
               RCV_OPEN:   rsp_tready <= 1'b1;
               RCV_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               RCV_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_tready <= 1'b0;
                  end else begin
                     rsp_tready <= 1'b1;
                     if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(5, 30);
                  end
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- monitor and checker

   rsp_fields_type exp_rsp;
   rsp_fields_type got_rsp;

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $error("response %0d field %s: expected 0x%0h, got 0x%0h",
                rsp_checked, name, exp_v, got_v);
         err_count++;
      end
   endtask

   // sampled at the rising edge; requests are predicted in the order the block takes them
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rsp_expect_q.push_back(trigger_predict(req_pending_q[0]));
            req_pending_q.pop_front();
            offer_live = 1'b0;
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expect_q.size() == 0) begin
               $error("response with no request waiting: tdata 0x%0h", rsp_tdata);
               err_count++;
            end else begin
               exp_rsp = rsp_expect_q.pop_front();
               got_rsp = rsp_fields_type'(rsp_tdata[RSP_BITS-1:0]);
               check_field("break_flag", 32'(exp_rsp.break_flag), 32'(got_rsp.break_flag));
               check_field("event_bits", 32'(exp_rsp.event_bits), 32'(got_rsp.event_bits));
               check_field("debugged_program", exp_rsp.debugged_program,
                           got_rsp.debugged_program);
               check_field("break_line", 32'(exp_rsp.break_line), 32'(got_rsp.break_line));
               check_field("break_sub_ref", 32'(exp_rsp.break_sub_ref),
                           32'(got_rsp.break_sub_ref));
               check_field("error_code", 32'(exp_rsp.error_code), 32'(got_rsp.error_code));
               check_field("zero_fill", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:RSP_BITS]));
               if (exp_rsp.break_flag) n_breaks++;
               if (exp_rsp.event_bits[0]) n_tbl_hits++;
               if (exp_rsp.event_bits[1]) n_watch++;
               if (exp_rsp.error_code == ERR_FULL) n_full++;
               if (exp_rsp.error_code == ERR_ILLEGAL) n_illegal++;
            end
            rsp_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due",
                  cycle_count, rsp_expect_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   int dir_count;
   int ses_pick;
   int en_pick;

   initial begin
      // directed part
      line_ev(16'd5, 8'd9, 32'hFFFF_FFFF, 1'b1);          // debugging off: no break
      push_req(base_item(ACT_UNUSED, 4'($urandom)));      // unused action, ignored
      enable_req(1'b1);                                   // step one line
      line_ev(16'd10, 8'd0, PID_A, 1'b0);                 // break, program recorded
      cmd(BT_ADD, 17'h0_0064);                            // line 100
      cmd(BT_ADD, 17'h1_FFFF);                            // qualifier cut to line 65535
      cmd(BT_RUN, 17'h0_0000);
      line_ev(16'd100, 8'd3, PID_A, 1'b0);                // table hit
      line_ev(16'd65535, 8'd255, 32'hFFFF_FFFF, 1'b1);    // table and watch hit
      cmd(BT_STEP, 17'h1_0001);                           // high bit dropped, count 1
      line_ev(16'd1, 8'd7, PID_A, 1'b0);
      cmd(BT_STEP_LINE, 17'h0_0001);
      line_ev(16'd2, 8'd5, PID_A, 1'b0);                  // inside a line: no count
      line_ev(16'd3, 8'd0, PID_A, 1'b0);
      cmd(BT_TO_LINE, 17'h0_00C8);
      line_ev(16'd200, 8'd0, PID_A, 1'b0);
      parent_cmd(BT_PARENT, 15'd3, 16'd7);
      depth_ev(15'd2, 16'd6, PID_A);                      // back in the caller
      parent_cmd(BT_PARENT_PRG, 15'd0, 16'hFFFF);         // parent word wraps negative
      depth_ev(15'h7FFF, 16'hFFFF, PID_A);
      cmd(BT_TRACE, 17'h0_0000);
      cmd(BT_GOTO, 17'h0_0000);
      line_ev(16'd4, 8'd0, PID_A, 1'b0);                  // any other mode breaks
      cmd(BT_CLEAR_LINE, 17'h1_FF9C);                     // negative line matches nothing
      cmd(BT_CLEAR_LINE, 17'h0_0064);                     // removes and compacts
      cmd(BT_ILLEGAL_MAX, 17'h0_0000);                    // illegal type
      cmd(BT_CLEAR, 17'h0_0000);
      enable_req(1'b0);
      dir_count = req_counted;

      // random part, opening with a table fill session
      gen_session(SES_FILL);
      while (req_counted < dir_count + RANDOM_ITEMS) begin
         en_pick = $urandom_range(0, 19);
         if (en_pick < 17) enable_req(1'b1);
         else if (en_pick == 17) enable_req(1'b0);
         ses_pick = $urandom_range(0, 99);
         if (ses_pick < 30) gen_session(SES_TABLE);
         else if (ses_pick < 45) gen_session(SES_STEP);
         else if (ses_pick < 57) gen_session(SES_TO_LINE);
         else if (ses_pick < 72) gen_session(SES_PARENT);
         else if (ses_pick < 80) gen_session(SES_FILL);
         else gen_session(SES_NOISE);
      end

      // reset once, released at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests taken, all responses in, then a tail for stray output
      while (req_pending_q.size() != 0 || offer_live) @(negedge clock);
      while (rsp_expect_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d requests, %0d responses in %0d cycles",
               req_accepted, rsp_checked, cycle_count);
      $display("  %0d breaks (%0d table, %0d watch), %0d table-full and %0d illegal-type errors",
               n_breaks, n_tbl_hits, n_watch, n_full, n_illegal);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
